@@ rtl/crcfr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// crcfr_pkg
// shared types, codes and the crc-16/modbus byte fold for the frame receiver
// ----------------------------------------------------------------------------
package crcfr_pkg;

  localparam logic [7:0]  SYNC_FIRST  = 8'hA5;
  localparam logic [7:0]  SYNC_SECOND = 8'h5A;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'hA001;
  localparam logic [7:0]  MIN_LENGTH  = 8'd8;
  localparam logic [7:0]  KIND_OFFSET = 8'd6;
  localparam logic [7:0]  LEN_OFFSET  = 8'd2;
  localparam logic [7:0]  BODY_START  = 8'd3;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_CRC_ERR = 2'd1;
  localparam logic [1:0] STATUS_SHORT   = 2'd2;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic       is_end;
    logic [7:0] body_byte;
    logic [7:0] byte_pos;
    logic [1:0] status;
    logic       kind_is_zero;
  } res_t;

  typedef struct packed {
    logic valid;
    res_t res;
  } push_t;

  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

@@ rtl/crc_checked_frame_receiver_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// crc_checked_frame_receiver_top
// framed byte receiver with sync hunt and crc-16/modbus check
// ----------------------------------------------------------------------------
// Up to one byte is accepted every cycle. The parser handles each byte in the
// cycle it is accepted, folding it into the crc a whole byte at a time, and
// puts any result into a queue of QueueDepth entries; a result shows on the
// output in the cycle after its byte at the earliest. The input stalls only
// while that queue is full, which with QueueDepth >= 2 needs an output stall.
module crc_checked_frame_receiver_top import crcfr_pkg::*; #(
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] rx_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic            is_end_o,
  output logic [7:0]      body_byte_o,
  output logic [7:0]      byte_pos_o,
  output logic [1:0]      status_o,
  output logic            kind_is_zero_o
);

  push_t push;
  res_t  out_res;
  logic  full;
  logic  accept;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  crcfr_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_byte_i (rx_byte_i),
    .push_o    (push)
  );

  crcfr_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res)
  );

  assign is_end_o       = out_res.is_end;
  assign body_byte_o    = out_res.body_byte;
  assign byte_pos_o     = out_res.byte_pos;
  assign status_o       = out_res.status;
  assign kind_is_zero_o = out_res.kind_is_zero;

`ifndef SYNTH
  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty queue");

  a_body_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !is_end_o) |-> (status_o == STATUS_OK && !kind_is_zero_o
      && byte_pos_o >= BODY_START))
    else $error("body beat carries end fields");

  a_end_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_end_o) |-> (body_byte_o == 8'h00 && status_o != 2'd3))
    else $error("end beat carries body data");

  a_short_no_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_end_o && status_o == STATUS_SHORT) |->
      (!kind_is_zero_o && byte_pos_o == LEN_OFFSET))
    else $error("short frame end beat malformed");
`endif

endmodule
`default_nettype wire

@@ rtl/crcfr_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// crcfr_front
// sync hunt, length capture, crc fold and result classification per byte
// ----------------------------------------------------------------------------
module crcfr_front import crcfr_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] rx_byte_i,
  output push_t           push_o
);

  localparam logic [1:0] PH_HUNT1 = 2'd0;
  localparam logic [1:0] PH_HUNT2 = 2'd1;
  localparam logic [1:0] PH_LEN   = 2'd2;
  localparam logic [1:0] PH_FRAME = 2'd3;

  logic [1:0]  phase_q, phase_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  pos_q, pos_d;
  logic [7:0]  crc_lo_q, crc_lo_d;
  logic        kind_q, kind_d;
  logic [8:0]  pos_p3;
  logic [8:0]  pos_p2;
  logic        crc_ok;

  assign pos_p3 = {1'b0, pos_q} + 9'd3;
  assign pos_p2 = {1'b0, pos_q} + 9'd2;
  assign crc_ok = (crc_lo_q == crc_q[7:0]) && (rx_byte_i == crc_q[15:8]);

  always_comb begin
    phase_d  = phase_q;
    crc_d    = crc_q;
    len_d    = len_q;
    pos_d    = pos_q;
    crc_lo_d = crc_lo_q;
    kind_d   = kind_q;
    push_o   = '0;
    if (accept_i) begin
      case (phase_q)
        PH_HUNT1: begin
          if (rx_byte_i == SYNC_FIRST) phase_d = PH_HUNT2;
        end
        PH_HUNT2: begin
          if (rx_byte_i == SYNC_SECOND) begin
            phase_d = PH_LEN;
          end else if (rx_byte_i != SYNC_FIRST) begin
            phase_d = PH_HUNT1;
          end
        end
        PH_LEN: begin
          len_d    = rx_byte_i;
          kind_d   = 1'b0;
          crc_lo_d = 8'h00;
          if (rx_byte_i < MIN_LENGTH) begin
            phase_d                  = PH_HUNT1;
            crc_d                    = CRC_INIT;
            push_o.valid             = 1'b1;
            push_o.res.is_end        = 1'b1;
            push_o.res.byte_pos      = LEN_OFFSET;
            push_o.res.status        = STATUS_SHORT;
          end else begin
            crc_d   = crc_fold(CRC_INIT, rx_byte_i);
            pos_d   = BODY_START;
            phase_d = PH_FRAME;
          end
        end
        PH_FRAME: begin
          if (pos_q == KIND_OFFSET) kind_d = (rx_byte_i == 8'h00);
          if (pos_p3 <= {1'b0, len_q}) begin
            crc_d                = crc_fold(crc_q, rx_byte_i);
            pos_d                = pos_q + 8'd1;
            push_o.valid         = 1'b1;
            push_o.res.body_byte = rx_byte_i;
            push_o.res.byte_pos  = pos_q;
            push_o.res.status    = STATUS_OK;
          end else if (pos_p2 == {1'b0, len_q}) begin
            crc_lo_d = rx_byte_i;
            pos_d    = pos_q + 8'd1;
          end else begin
            push_o.valid            = 1'b1;
            push_o.res.is_end       = 1'b1;
            push_o.res.byte_pos     = pos_q;
            push_o.res.status       = crc_ok ? STATUS_OK : STATUS_CRC_ERR;
            push_o.res.kind_is_zero = kind_q;
            phase_d                 = PH_HUNT1;
            crc_d                   = CRC_INIT;
            pos_d                   = 8'h00;
          end
        end
        default: begin
          phase_d = PH_HUNT1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT1;
      crc_q    <= CRC_INIT;
      len_q    <= 8'h00;
      pos_q    <= 8'h00;
      crc_lo_q <= 8'h00;
      kind_q   <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      crc_q    <= crc_d;
      len_q    <= len_d;
      pos_q    <= pos_d;
      crc_lo_q <= crc_lo_d;
      kind_q   <= kind_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/crcfr_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// crcfr_queue
// result queue between the parser and the output channel
// ----------------------------------------------------------------------------
module crcfr_queue import crcfr_pkg::*; #(
  parameter int Depth = QUEUE_DEPTH
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire push_t push_i,
  output logic       full_o,
  output logic       out_valid_o,
  input  wire logic  out_stall_i,
  output res_t       out_res_o
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LAST = AW'(Depth - 1);
  localparam logic [CW-1:0] FULL = CW'(Depth);

  res_t          mem_q [Depth];
  logic [AW-1:0] wr_q, wr_d;
  logic [AW-1:0] rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          pop;

  assign full_o      = (cnt_q == FULL);
  assign out_valid_o = (cnt_q != '0);
  assign out_res_o   = mem_q[rd_q];
  assign pop         = out_valid_o && !out_stall_i;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i.valid) wr_d = (wr_q == LAST) ? '0 : wr_q + AW'(1);
    if (pop) rd_d = (rd_q == LAST) ? '0 : rd_q + AW'(1);
    if (push_i.valid && !pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop && !push_i.valid) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) mem_q[wr_q] <= push_i.res;
  end

endmodule
`default_nettype wire
